/* rtl/rgb2yuv_pkg.sv */
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// No dependencies.
`default_nettype none

package rgb2yuv_pkg;

   // Field widths
   localparam int COMP_W = 8;
   localparam int PIX_W  = 3 * COMP_W;
   localparam int CFG_W  = 13;
   localparam int ROW_W  = 12;

   // Frame size limits and register reset values
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int MAX_HEIGHT        = 4096;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   // Register map
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // BT.601 studio-range coefficients
   localparam int Y_R_COEF  = 66;
   localparam int Y_G_COEF  = 129;
   localparam int Y_B_COEF  = 25;
   localparam int Y_OFFSET  = 'h1080;
   localparam int U_B_COEF  = 112;
   localparam int U_G_COEF  = 74;
   localparam int U_R_COEF  = 38;
   localparam int V_R_COEF  = 112;
   localparam int V_G_COEF  = 94;
   localparam int V_B_COEF  = 18;
   localparam int UV_OFFSET = 'h8080;

   // How the chroma sample of a pixel is formed
   typedef enum logic [2:0] {
      CHROMA_NONE,    // pixel does not close a block
      CHROMA_QUAD,    // full 2x2 block
      CHROMA_VPAIR,   // odd width: last column, two rows
      CHROMA_HPAIR,   // odd height: last row, two columns
      CHROMA_SINGLE   // odd width and height: corner pixel alone
   } chroma_mode_type;

endpackage

`default_nettype wire

/* rtl/rgb2yuv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none

module rgb2yuv_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/rgb_to_yuv420_converter.sv */
// RGB to YUV 4:2:0 converter (BT.601 studio range), top level.
// Depends on rgb2yuv_pkg and rgb2yuv_ram.
//
// Usage:
//  - req_* carries one RGB pixel per request, raster order, frame after frame.
//  - rsp_* returns one result per pixel: its luma, plus Cb/Cr on the pixel
//    that closes a 2x2 or odd-edge block (rsp_tuser high), and rsp_tlast on the last
//    pixel of the frame. Chroma bytes are zero when rsp_tuser is low.
//  - csr_* writes image_width (index 0) and image_height (index 1). Write
//    only with the pipeline drained; a change inside a frame applies from
//    the next request on.
//  - Throughput: one pixel per clock while results are taken. Latency:
//    three register stages (line store read, averaging/luma, chroma
//    matrix), the last of which drives rsp_*.
//  - Even rows are written into a line store RAM; odd rows read it back one
//    pixel per cycle, as requests are accepted, through its single read port.
//  - A stalled receiver freezes the whole pipeline; req_tready drops as soon
//    as the output register is full and not taken.
//  - Reset (synchronous, active high) empties the pipeline, zeroes the
//    row/column counters and left pixel, and restores 640x480. The line
//    store is not cleared; it needs no clearing pass.
`default_nettype none

module rgb_to_yuv420_converter
   import rgb2yuv_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // pixel requests
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [23:0]      req_tdata,   // red[7:0], green[15:8], blue[23:16]
   // results
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [23:0]           rsp_tdata,   // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
   output logic                  rsp_tuser,   // chroma_valid
   output logic                  rsp_tlast,   // frame_end
   // configuration
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);              // column counter width
   localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W; // width compare width
   localparam logic [XW-1:0]    MAX_W_X = XW'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] MAX_H_X = CFG_W'(MAX_HEIGHT);

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Effective sizes: zero counts as one, oversize saturates.
   logic [XW-1:0]    width_x, width_eff;
   logic [CFG_W-1:0] height_eff;

   always_comb begin
      width_x = XW'(width_ff);
      if (width_ff == '0)
         width_eff = XW'(1);
      else if (width_x > MAX_W_X)
         width_eff = MAX_W_X;
      else
         width_eff = width_x;

      if (height_ff == '0)
         height_eff = CFG_W'(1);
      else if (height_ff > MAX_H_X)
         height_eff = MAX_H_X;
      else
         height_eff = height_ff;
   end

   // ---------------------------------------------------------------- control
   logic advance;
   logic accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ---------------------------------------------------------------- stage 0
   // Position tracking, chroma mode decision, line store access.
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic             last_col, last_row;
   chroma_mode_type  mode;

   assign last_col = (XW'(col_ff) + XW'(1)) >= width_eff;
   assign last_row = (CFG_W'(row_ff) + CFG_W'(1)) >= height_eff;

   always_comb begin
      mode = CHROMA_NONE;
      if (row_ff[0]) begin
         if (col_ff[0])
            mode = CHROMA_QUAD;
         else if (last_col)
            mode = CHROMA_VPAIR;
      end else if (last_row) begin
         if (col_ff[0])
            mode = CHROMA_HPAIR;
         else if (last_col)
            mode = CHROMA_SINGLE;
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         left_in = req_tdata;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
      end
   end

   // Even rows write the line store, odd rows read it at the same column.
   logic [PIX_W-1:0] store_q;

   rgb2yuv_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && !row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (accept && row_ff[0]),
      .rd_addr (col_ff),
      .rd_data (store_q)
   );

   // ---------------------------------------------------------------- stage 1
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff, s1_pix_in;
   logic [PIX_W-1:0] s1_left_ff, s1_left_in;
   chroma_mode_type  s1_mode_ff, s1_mode_in;
   logic             s1_end_ff, s1_end_in;
   // store word of the previous pixel (column - 1 on a quad)
   logic [PIX_W-1:0] prev_q_ff, prev_q_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pix_in   = s1_pix_ff;
      s1_left_in  = s1_left_ff;
      s1_mode_in  = s1_mode_ff;
      s1_end_in   = s1_end_ff;
      prev_q_in   = prev_q_ff;
      if (advance) begin
         s1_valid_in = accept;
         s1_pix_in   = req_tdata;
         s1_left_in  = left_ff;
         s1_mode_in  = mode;
         s1_end_in   = last_col && last_row;
         if (s1_valid_ff)
            prev_q_in = store_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_pix_ff  <= s1_pix_in;
      s1_left_ff <= s1_left_in;
      s1_mode_ff <= s1_mode_in;
      s1_end_ff  <= s1_end_in;
      prev_q_ff  <= prev_q_in;
   end

   // Truncating average of one component; a = store col-1, b = store col,
   // c = left pixel, d = current pixel.
   function automatic logic [COMP_W-1:0] avg_comp(
      input chroma_mode_type m,
      input logic [COMP_W-1:0] a,
      input logic [COMP_W-1:0] b,
      input logic [COMP_W-1:0] c,
      input logic [COMP_W-1:0] d
   );
      logic [COMP_W+1:0] sum4;
      logic [COMP_W:0]   sum_v;
      logic [COMP_W:0]   sum_h;
      logic [COMP_W-1:0] res;
      sum4  = (COMP_W+2)'(a) + (COMP_W+2)'(b) + (COMP_W+2)'(c) + (COMP_W+2)'(d);
      sum_v = (COMP_W+1)'(b) + (COMP_W+1)'(d);
      sum_h = (COMP_W+1)'(c) + (COMP_W+1)'(d);
      case (m)
         CHROMA_QUAD:   res = sum4[COMP_W+1:2];
         CHROMA_VPAIR:  res = sum_v[COMP_W:1];
         CHROMA_HPAIR:  res = sum_h[COMP_W:1];
         CHROMA_SINGLE: res = d;
         default:       res = '0;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- stage 2
   logic              s2_valid_ff, s2_valid_in;
   logic [COMP_W-1:0] s2_luma_ff, s2_luma_in;
   logic [PIX_W-1:0]  s2_avg_ff, s2_avg_in;
   logic              s2_chroma_ff, s2_chroma_in;
   logic              s2_end_ff, s2_end_in;
   logic [16:0]       luma_sum;
   logic [PIX_W-1:0]  avg_pix;

   assign luma_sum = 17'(Y_R_COEF) * 17'(s1_pix_ff[7:0])
                   + 17'(Y_G_COEF) * 17'(s1_pix_ff[15:8])
                   + 17'(Y_B_COEF) * 17'(s1_pix_ff[23:16])
                   + 17'(Y_OFFSET);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         avg_pix[i*COMP_W +: COMP_W] = avg_comp(s1_mode_ff,
                                                prev_q_ff[i*COMP_W +: COMP_W],
                                                store_q[i*COMP_W +: COMP_W],
                                                s1_left_ff[i*COMP_W +: COMP_W],
                                                s1_pix_ff[i*COMP_W +: COMP_W]);
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_luma_in   = s2_luma_ff;
      s2_avg_in    = s2_avg_ff;
      s2_chroma_in = s2_chroma_ff;
      s2_end_in    = s2_end_ff;
      if (advance) begin
         s2_valid_in  = s1_valid_ff;
         s2_luma_in   = luma_sum[15:8];
         s2_avg_in    = avg_pix;
         s2_chroma_in = (s1_mode_ff != CHROMA_NONE);
         s2_end_in    = s1_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_luma_ff   <= s2_luma_in;
      s2_avg_ff    <= s2_avg_in;
      s2_chroma_ff <= s2_chroma_in;
      s2_end_ff    <= s2_end_in;
   end

   // ---------------------------------------------------------------- stage 3
   // Chroma matrix; offsets keep both sums non-negative for 8-bit averages.
   logic [COMP_W-1:0] avg_r, avg_g, avg_b;
   logic [16:0]       u_sum, v_sum;

   assign avg_r = s2_avg_ff[7:0];
   assign avg_g = s2_avg_ff[15:8];
   assign avg_b = s2_avg_ff[23:16];

   assign u_sum = (17'(U_B_COEF) * 17'(avg_b) + 17'(UV_OFFSET))
                - (17'(U_G_COEF) * 17'(avg_g) + 17'(U_R_COEF) * 17'(avg_r));
   assign v_sum = (17'(V_R_COEF) * 17'(avg_r) + 17'(UV_OFFSET))
                - (17'(V_G_COEF) * 17'(avg_g) + 17'(V_B_COEF) * 17'(avg_b));

   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = s2_valid_ff;
         rsp_user_in  = s2_chroma_ff;
         rsp_last_in  = s2_end_ff;
         rsp_data_in  = {s2_chroma_ff ? v_sum[15:8] : 8'd0,
                         s2_chroma_ff ? u_sum[15:8] : 8'd0,
                         s2_luma_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
